FILE: rtl/core/single_neuron_sigmoid_trainer_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the neuron trainer
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SINGLE_NEURON_SIGMOID_TRAINER_TOP_ASSERT_SVH
`define SINGLE_NEURON_SIGMOID_TRAINER_TOP_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define SNST_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define SNST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/snst_pkg.sv
// ----------------------------------------------------------------------------
// snst_pkg
// Types, codes, widths and the sigmoid table of the neuron trainer.
// ----------------------------------------------------------------------------
package snst_pkg;

	localparam int MAX_FEATURES = 4;
	localparam int LANE_W       = 2;
	localparam int SIG_ENTRIES  = 256;
	localparam int SIG_IDX_W    = 8;
	localparam int SIG_FRAC_W   = 32 - SIG_IDX_W;
	localparam int ACC_W        = 50;
	localparam int ADJ_W        = 48;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FEATURES_IN_USE = 2'd1;

	typedef enum logic [2:0] {
		MODE_STORE      = 3'd0,
		MODE_TRAIN      = 3'd1,
		MODE_INFER      = 3'd2,
		MODE_SET_WEIGHT = 3'd3,
		MODE_CLEAR      = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		KIND_STORED     = 3'd0,
		KIND_TRAINED    = 3'd1,
		KIND_PREDICTION = 3'd2,
		KIND_WEIGHT_SET = 3'd3,
		KIND_ERROR      = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DISPATCH, ST_ITER, ST_SAMPLE, ST_DOT, ST_SIG,
		ST_DV, ST_DELTA, ST_ADJ, ST_UPD, ST_RESP
	} ctl_state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_CAPTURE, OP_STORE, OP_CLEAR, OP_SET_WEIGHT, OP_CLEAR_ADJ,
		OP_READ_SAMPLE, OP_DOT, OP_SIGMOID, OP_SLOPE, OP_DELTA, OP_ADJUST,
		OP_UPDATE, OP_RESULT
	} dp_op_t;

	typedef struct packed {
		dp_op_t              op;
		logic [LANE_W-1:0]   lane;
		kind_t               kind;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic store_full;
	} dp_stat_t;

	typedef logic [15:0] sig_tab_t [SIG_ENTRIES+1];

	// unsigned quotient by shift and subtract, used at elaboration only
	function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] dvs);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= dvs) begin
				r    = r - dvs;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-f) in Q30 for f in [0,1] in Q30, Taylor series truncated after the f^20 term
	function automatic longint exp_neg_frac(longint unsigned f30);
		longint unsigned term;
		longint          sum;
		term = 64'd1 << 30;
		sum  = longint'(64'd1 << 30);
		for (int k = 1; k <= 20; k++) begin
			term = udiv64((term * f30) >> 30, 64'(k));
			if ((k & 1) == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		return sum;
	endfunction

	// table points over [-8,8] in Q0.16, evaluated at elaboration
	function automatic sig_tab_t build_sig_tab();
		sig_tab_t        t;
		longint          e1, g, e, den, s, v;
		longint unsigned a, n;
		e1 = exp_neg_frac(64'd1 << 30);
		for (int i = 0; i <= SIG_ENTRIES; i++) begin
			g = ((longint'(i) <<< 32) / SIG_ENTRIES) - (longint'(1) <<< 31);
			a = (g < 0) ? longint'(-g) : longint'(g);
			n = a >> 28;
			e = exp_neg_frac((a & 64'h0FFF_FFFF) << 2);
			for (longint unsigned r = 0; r < n; r++)
				e = (e * e1) >>> 30;
			den = (longint'(1) <<< 30) + e;
			s = longint'(udiv64(64'((longint'(1) <<< 46) + (den >>> 1)), 64'(den)));
			v = (g >= 0) ? s : 65536 - s;
			if (v > 65535)
				v = 65535;
			if (v < 0)
				v = 0;
			t[i] = 16'(v);
		end
		return t;
	endfunction

	localparam sig_tab_t SIG_TAB = build_sig_tab();

endpackage

FILE: rtl/core/snst_in_if.sv
// ----------------------------------------------------------------------------
// snst_in_if
// Request channel into the neuron trainer.
// ----------------------------------------------------------------------------
interface snst_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         mode;
	logic signed [15:0] feature_a;
	logic signed [15:0] feature_b;
	logic signed [15:0] feature_c;
	logic signed [15:0] feature_d;
	logic [15:0]        target;
	logic [1:0]         weight_slot;
	logic signed [31:0] weight_value;

	modport source (output valid, mode, feature_a, feature_b, feature_c, feature_d,
		target, weight_slot, weight_value, input ready);
	modport sink (input valid, mode, feature_a, feature_b, feature_c, feature_d,
		target, weight_slot, weight_value, output ready);
endinterface

FILE: rtl/core/snst_out_if.sv
// ----------------------------------------------------------------------------
// snst_out_if
// Result channel out of the neuron trainer.
// ----------------------------------------------------------------------------
interface snst_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         kind;
	logic [15:0]        prediction;
	logic signed [31:0] weight_out_a;
	logic signed [31:0] weight_out_b;
	logic signed [31:0] weight_out_c;
	logic signed [31:0] weight_out_d;

	modport source (output valid, kind, prediction, weight_out_a, weight_out_b,
		weight_out_c, weight_out_d, input ready);
	modport sink (input valid, kind, prediction, weight_out_a, weight_out_b,
		weight_out_c, weight_out_d, output ready);
endinterface

FILE: rtl/core/snst_cfg_if.sv
// ----------------------------------------------------------------------------
// snst_cfg_if
// Register write channel of the neuron trainer.
// ----------------------------------------------------------------------------
interface snst_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/snst_datapath.sv
// ----------------------------------------------------------------------------
// snst_datapath
// Sample store, weights, dot product, sigmoid and gradient arithmetic.
// ----------------------------------------------------------------------------
module snst_datapath import snst_pkg::*; #(
	parameter int MAX_SAMPLES = 16,
	parameter int CNT_W = 5,
	parameter int IDX_W = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	input  logic [IDX_W-1:0]    rd_idx,
	output dp_stat_t            stat,
	output logic [CNT_W-1:0]    sample_count,
	input  logic signed [15:0]  feature_a,
	input  logic signed [15:0]  feature_b,
	input  logic signed [15:0]  feature_c,
	input  logic signed [15:0]  feature_d,
	input  logic [15:0]         target,
	input  logic [1:0]          weight_slot,
	input  logic signed [31:0]  weight_value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          kind,
	output logic [15:0]         prediction,
	output logic signed [31:0]  weight_out_a,
	output logic signed [31:0]  weight_out_b,
	output logic signed [31:0]  weight_out_c,
	output logic signed [31:0]  weight_out_d
);

	logic [63:0] feat_mem [MAX_SAMPLES];
	logic [15:0] tgt_mem [MAX_SAMPLES];

	logic signed [15:0]      x_q [MAX_FEATURES];
	logic [15:0]             tgt_q;
	logic [1:0]              slot_q;
	logic signed [31:0]      wval_q;
	logic signed [31:0]      w_q [MAX_FEATURES];
	logic signed [ADJ_W-1:0] adj_q [MAX_FEATURES];
	logic signed [ACC_W-1:0] acc_q;
	logic [15:0]             sig_q;
	logic signed [16:0]      err_q;
	logic [16:0]             dv_q;
	logic signed [16:0]      delta_q;
	logic [CNT_W-1:0]        count_q;
	logic                    out_valid_q;
	logic [2:0]              kind_q;
	logic [15:0]             pred_q;
	logic signed [31:0]      wout_q [MAX_FEATURES];

	// dot-product step
	logic signed [47:0]      dot_prod;
	logic signed [ACC_W-1:0] acc_d;
	// sigmoid lookup
	logic                    z_in_range;
	logic [31:0]             z_u;
	logic [SIG_IDX_W-1:0]    tab_idx;
	logic [SIG_FRAC_W-1:0]   tab_frac;
	logic [15:0]             tab_lo, tab_hi;
	logic signed [16:0]      tab_diff;
	logic signed [SIG_FRAC_W+17:0] interp;
	logic [15:0]             sig_d;
	// slope and delta
	logic [16:0]             one_minus;
	logic [32:0]             slope_prod;
	logic signed [35:0]      delta_prod;
	// adjust and update
	logic signed [32:0]      adj_prod;
	logic signed [48:0]      w_sum;
	logic signed [31:0]      w_sat;

	assign dot_prod = w_q[cmd.lane] * x_q[cmd.lane];
	assign acc_d = ((cmd.lane == '0) ? ACC_W'(0) : acc_q) + ACC_W'(dot_prod);

	assign z_in_range = (acc_q[ACC_W-1:31] == '0) || (acc_q[ACC_W-1:31] == '1);
	assign z_u        = {~acc_q[31], acc_q[30:0]};
	assign tab_idx    = z_u[31 -: SIG_IDX_W];
	assign tab_frac   = z_u[SIG_FRAC_W-1:0];
	assign tab_lo     = SIG_TAB[{1'b0, tab_idx}];
	assign tab_hi     = SIG_TAB[{1'b0, tab_idx} + 1'b1];
	assign tab_diff   = $signed({1'b0, tab_hi}) - $signed({1'b0, tab_lo});
	assign interp     = tab_diff * $signed({1'b0, tab_frac});

	always_comb begin
		if (!z_in_range && acc_q[ACC_W-1])
			sig_d = SIG_TAB[0];
		else if (!z_in_range)
			sig_d = SIG_TAB[SIG_ENTRIES];
		else
			sig_d = 16'($signed({1'b0, tab_lo}) + (interp >>> SIG_FRAC_W));
	end

	assign one_minus  = 17'h10000 - {1'b0, sig_q};
	assign slope_prod = sig_q * one_minus;
	assign delta_prod = err_q * $signed({1'b0, dv_q});
	assign adj_prod   = x_q[cmd.lane] * delta_q;

	assign w_sum = 49'(w_q[cmd.lane]) + 49'(adj_q[cmd.lane] >>> 12);
	always_comb begin
		if (w_sum > 49'sd2147483647)
			w_sat = 32'sh7FFF_FFFF;
		else if (w_sum < -49'sd2147483648)
			w_sat = 32'sh8000_0000;
		else
			w_sat = w_sum[31:0];
	end

	// sample store, registered read
	always_ff @(posedge clk) begin
		if (cmd.op == OP_STORE) begin
			feat_mem[count_q[IDX_W-1:0]] <= {x_q[3], x_q[2], x_q[1], x_q[0]};
			tgt_mem[count_q[IDX_W-1:0]]  <= tgt_q;
		end
	end

	// working payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPTURE: begin
				x_q[0] <= feature_a;
				x_q[1] <= feature_b;
				x_q[2] <= feature_c;
				x_q[3] <= feature_d;
				tgt_q  <= target;
				slot_q <= weight_slot;
				wval_q <= weight_value;
			end
			OP_READ_SAMPLE: begin
				for (int j = 0; j < MAX_FEATURES; j++)
					x_q[j] <= feat_mem[rd_idx][16*j +: 16];
				tgt_q <= tgt_mem[rd_idx];
			end
			OP_DOT:     acc_q <= acc_d;
			OP_SIGMOID: sig_q <= sig_d;
			OP_SLOPE: begin
				dv_q  <= slope_prod[32:16];
				err_q <= $signed({1'b0, tgt_q}) - $signed({1'b0, sig_q});
			end
			OP_DELTA:   delta_q <= delta_prod[32:16];
			default: ;
		endcase
	end

	// weights, adjust sums, sample count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int j = 0; j < MAX_FEATURES; j++) begin
				w_q[j]   <= '0;
				adj_q[j] <= '0;
			end
		end else begin
			case (cmd.op)
				OP_STORE:      count_q <= count_q + 1'b1;
				OP_CLEAR:      count_q <= '0;
				OP_SET_WEIGHT: begin
					if (32'(slot_q) < 32'(MAX_FEATURES))
						w_q[slot_q] <= wval_q;
				end
				OP_CLEAR_ADJ: begin
					for (int j = 0; j < MAX_FEATURES; j++)
						adj_q[j] <= '0;
				end
				OP_ADJUST:     adj_q[cmd.lane] <= adj_q[cmd.lane] + ADJ_W'(adj_prod);
				OP_UPDATE:     w_q[cmd.lane] <= w_sat;
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.op == OP_RESULT)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_RESULT) begin
			kind_q <= cmd.kind;
			pred_q <= (cmd.kind == KIND_PREDICTION) ? sig_q : 16'd0;
			for (int j = 0; j < MAX_FEATURES; j++)
				wout_q[j] <= w_q[j];
		end
	end

	assign stat.out_free   = !out_valid_q || out_ready;
	assign stat.store_full = (count_q == CNT_W'(MAX_SAMPLES));
	assign sample_count    = count_q;
	assign out_valid       = out_valid_q;
	assign kind            = kind_q;
	assign prediction      = pred_q;
	assign weight_out_a    = wout_q[0];
	assign weight_out_b    = wout_q[1];
	assign weight_out_c    = wout_q[2];
	assign weight_out_d    = wout_q[3];

endmodule

FILE: rtl/core/snst_controller.sv
// ----------------------------------------------------------------------------
// snst_controller
// Sequencer over requests, iterations, samples and lanes; holds registers.
// ----------------------------------------------------------------------------
module snst_controller import snst_pkg::*; #(
	parameter int CNT_W = 5,
	parameter int IDX_W = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [2:0]            in_mode,
	output logic                  in_ready,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  cfg_ready,
	input  dp_stat_t              stat,
	input  logic [CNT_W-1:0]      sample_count,
	output dp_cmd_t               cmd,
	output logic [IDX_W-1:0]      rd_idx
);

	ctl_state_t        state_q, state_d;
	logic [2:0]        mode_q;
	kind_t             kind_q;
	logic [15:0]       iter_cfg_q;
	logic [2:0]        feat_cfg_q;
	logic [15:0]       it_q;
	logic [CNT_W-1:0]  smp_q;
	logic [LANE_W-1:0] lane_q;
	logic [LANE_W-1:0] last_lane;
	logic              lane_end;

	always_comb begin
		if (feat_cfg_q == 3'd0)
			last_lane = '0;
		else if (32'(feat_cfg_q) > MAX_FEATURES)
			last_lane = LANE_W'(MAX_FEATURES - 1);
		else
			last_lane = LANE_W'(feat_cfg_q - 3'd1);
	end
	assign lane_end = (lane_q == last_lane);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign rd_idx    = smp_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_cfg_q <= 16'd10000;
			feat_cfg_q <= 3'd3;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ITERATION_COUNT: iter_cfg_q <= cfg_data;
				CFG_FEATURES_IN_USE: feat_cfg_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_DISPATCH;
			ST_DISPATCH: begin
				case (mode_q)
					MODE_TRAIN: state_d = ST_ITER;
					MODE_INFER: state_d = ST_DOT;
					default:    state_d = ST_RESP;
				endcase
			end
			ST_ITER:   state_d = (it_q == iter_cfg_q) ? ST_RESP : ST_SAMPLE;
			ST_SAMPLE: state_d = (smp_q == sample_count) ? ST_UPD : ST_DOT;
			ST_DOT:    if (lane_end) state_d = ST_SIG;
			ST_SIG:    state_d = (mode_q == MODE_TRAIN) ? ST_DV : ST_RESP;
			ST_DV:     state_d = ST_DELTA;
			ST_DELTA:  state_d = ST_ADJ;
			ST_ADJ:    if (lane_end) state_d = ST_SAMPLE;
			ST_UPD:    if (lane_end) state_d = ST_ITER;
			ST_RESP:   if (stat.out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd.op   = OP_NONE;
		cmd.lane = lane_q;
		cmd.kind = kind_q;
		case (state_q)
			ST_IDLE:     if (in_valid) cmd.op = OP_CAPTURE;
			ST_DISPATCH: begin
				case (mode_q)
					MODE_STORE:      if (!stat.store_full) cmd.op = OP_STORE;
					MODE_SET_WEIGHT: cmd.op = OP_SET_WEIGHT;
					MODE_CLEAR:      cmd.op = OP_CLEAR;
					default: ;
				endcase
			end
			ST_ITER:   if (it_q != iter_cfg_q) cmd.op = OP_CLEAR_ADJ;
			ST_SAMPLE: if (smp_q != sample_count) cmd.op = OP_READ_SAMPLE;
			ST_DOT:    cmd.op = OP_DOT;
			ST_SIG:    cmd.op = OP_SIGMOID;
			ST_DV:     cmd.op = OP_SLOPE;
			ST_DELTA:  cmd.op = OP_DELTA;
			ST_ADJ:    cmd.op = OP_ADJUST;
			ST_UPD:    cmd.op = OP_UPDATE;
			ST_RESP:   if (stat.out_free) cmd.op = OP_RESULT;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= '0;
			kind_q  <= KIND_ERROR;
			it_q    <= '0;
			smp_q   <= '0;
			lane_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: if (in_valid) mode_q <= in_mode;
				ST_DISPATCH: begin
					it_q   <= '0;
					lane_q <= '0;
					case (mode_q)
						MODE_STORE:      kind_q <= stat.store_full ? KIND_ERROR : KIND_STORED;
						MODE_TRAIN:      kind_q <= KIND_TRAINED;
						MODE_INFER:      kind_q <= KIND_PREDICTION;
						MODE_SET_WEIGHT: kind_q <= KIND_WEIGHT_SET;
						MODE_CLEAR:      kind_q <= KIND_STORED;
						default:         kind_q <= KIND_ERROR;
					endcase
				end
				ST_ITER:   smp_q <= '0;
				ST_SAMPLE: lane_q <= '0;
				ST_DOT:    if (!lane_end) lane_q <= lane_q + 1'b1;
				ST_SIG:    lane_q <= '0;
				ST_ADJ: begin
					if (lane_end)
						smp_q <= smp_q + 1'b1;
					else
						lane_q <= lane_q + 1'b1;
				end
				ST_UPD: begin
					if (lane_end) begin
						it_q   <= it_q + 1'b1;
						lane_q <= '0;
					end else begin
						lane_q <= lane_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/core/single_neuron_sigmoid_trainer_top.sv
// ----------------------------------------------------------------------------
// single_neuron_sigmoid_trainer_top
// Single sigmoid neuron with a sample store and full-batch gradient training.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake      contents
// in_ch     sink       valid/ready    mode, four Q4.12 features, target, weight write
// out_ch    source     valid/ready    kind, Q0.16 prediction, four Q16.16 weights
// cfg_ch    sink       valid/ready    register index and write data, always ready
//
// One request at a time, n = active lanes (1..4), S = stored samples:
// store, clear and set-weight go from dispatch to the result; infer walks n lanes.
// Train walks the n lanes twice per sample (dot product, adjust) over S samples,
// then once to update the weights, per iteration; each step has its own multiplier.
// A finished result sits in an output register while the next request is taken.
// Reset zeroes the weights and the sample count; the store needs no clearing pass.
//
module single_neuron_sigmoid_trainer_top import snst_pkg::*; #(
	parameter int MAX_SAMPLES = 16
) (
	input logic        clk,
	input logic        arst_n,
	snst_in_if.sink    in_ch,
	snst_out_if.source out_ch,
	snst_cfg_if.sink   cfg_ch
);

`include "single_neuron_sigmoid_trainer_top_assert.svh"

	// count holds 0..MAX_SAMPLES; index addresses the store
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic [CNT_W-1:0] sample_count;
	logic [IDX_W-1:0] rd_idx;

	// Sequence requests: iterations, samples and lanes advance here.
	snst_controller #(
		.CNT_W(CNT_W),
		.IDX_W(IDX_W)
	) u_ctl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_ch.valid),
		.in_mode      (in_ch.mode),
		.in_ready     (in_ch.ready),
		.cfg_valid    (cfg_ch.valid),
		.cfg_index    (cfg_ch.index),
		.cfg_data     (cfg_ch.data),
		.cfg_ready    (cfg_ch.ready),
		.stat         (stat),
		.sample_count (sample_count),
		.cmd          (cmd),
		.rd_idx       (rd_idx)
	);

	// Hold samples and weights; run one arithmetic step per command.
	snst_datapath #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.CNT_W(CNT_W),
		.IDX_W(IDX_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.rd_idx       (rd_idx),
		.stat         (stat),
		.sample_count (sample_count),
		.feature_a    (in_ch.feature_a),
		.feature_b    (in_ch.feature_b),
		.feature_c    (in_ch.feature_c),
		.feature_d    (in_ch.feature_d),
		.target       (in_ch.target),
		.weight_slot  (in_ch.weight_slot),
		.weight_value (in_ch.weight_value),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.kind         (out_ch.kind),
		.prediction   (out_ch.prediction),
		.weight_out_a (out_ch.weight_out_a),
		.weight_out_b (out_ch.weight_out_b),
		.weight_out_c (out_ch.weight_out_c),
		.weight_out_d (out_ch.weight_out_d)
	);

	// a taken request blocks the next one until its result is issued
	`SNST_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "request taken while busy")
	// never overwrite a result that has not been taken
	`SNST_ASSERT_NOW(a_result_slot_free, cmd.op == OP_RESULT, stat.out_free, "result register overrun")
	// an issued result shows on the channel in the next cycle
	`SNST_ASSERT_NEXT(a_result_shows, cmd.op == OP_RESULT, out_ch.valid, "issued result not presented")

endmodule

FILE: bench/snst_checker.sv
// ----------------------------------------------------------------------------
// snst_checker
// Watches the request, result and register channels of the neuron trainer.
// Predicts each result from its own model of the neuron and compares it field
// by field with what the block returns.
// ----------------------------------------------------------------------------
module snst_checker import snst_pkg::*; #(
	parameter int MAX_SAMPLES = 16
) (
	input  logic clk,
	input  logic arst_n,
	snst_in_if   in_ch,
	snst_out_if  out_ch,
	snst_cfg_if  cfg_ch,
	output int   errors,
	output int   pending
);

	localparam int NPTS = SIG_ENTRIES;

	typedef struct packed {
		logic [2:0]         kind;
		logic [15:0]        prediction;
		logic signed [31:0] wa;
		logic signed [31:0] wb;
		logic signed [31:0] wc;
		logic signed [31:0] wd;
	} outcome_t;

	outcome_t           outcomes_due[$];
	longint             sig_points[NPTS+1];
	logic signed [15:0] held_x[MAX_SAMPLES][4];
	logic [15:0]        held_target[MAX_SAMPLES];
	int                 held_count;
	longint             weight[4];
	longint             adj[4];
	int unsigned        iterations;
	logic [2:0]         lanes_cfg;

	function automatic longint exp_neg_q30(longint unsigned f);
		longint unsigned term;
		longint          acc;
		term = 64'd1 << 30;
		acc  = longint'(64'd1 << 30);
		for (int k = 1; k <= 20; k++) begin
			term = ((term * f) >> 30) / longint'(k);
			if (k % 2 == 1)
				acc -= longint'(term);
			else
				acc += longint'(term);
		end
		return acc;
	endfunction

	initial begin
		longint          e_one, g, e, den, s, v;
		longint unsigned mag, whole;
		e_one = exp_neg_q30(64'd1 << 30);
		for (int i = 0; i <= NPTS; i++) begin
			g = longint'((longint'(i) <<< 32) / NPTS) - (longint'(1) <<< 31);
			mag = (g < 0) ? -g : g;
			whole = mag >> 28;
			e = exp_neg_q30((mag & 64'h0FFF_FFFF) << 2);
			for (longint unsigned r = 0; r < whole; r++)
				e = (e * e_one) >>> 30;
			den = (longint'(1) <<< 30) + e;
			s = ((longint'(1) <<< 46) + den / 2) / den;
			v = (g >= 0) ? s : 65536 - s;
			if (v > 65535)
				v = 65535;
			if (v < 0)
				v = 0;
			sig_points[i] = v;
		end
	end

	function automatic longint sigmoid_of(longint z);
		longint unsigned pos, frac;
		longint          idx, d;
		if (z < -(longint'(1) <<< 31))
			return sig_points[0];
		if (z >= (longint'(1) <<< 31))
			return sig_points[NPTS];
		pos = longint'(z + (longint'(1) <<< 31)) * NPTS;
		idx = longint'(pos >> 32);
		frac = pos & 64'hFFFF_FFFF;
		d = sig_points[idx+1] - sig_points[idx];
		return sig_points[idx] + ((d * longint'(frac)) >>> 32);
	endfunction

	function automatic int active_lanes();
		if (lanes_cfg < 1)
			return 1;
		if (lanes_cfg > MAX_FEATURES)
			return MAX_FEATURES;
		return lanes_cfg;
	endfunction

	function automatic longint dot_with(longint x[4], int n);
		longint acc;
		acc = 0;
		for (int j = 0; j < n; j++)
			acc += weight[j] * x[j];
		return acc;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic void run_training();
		int     n;
		longint x[4];
		longint o, err, slope, delta;
		n = active_lanes();
		for (int unsigned it = 0; it < iterations; it++) begin
			for (int j = 0; j < 4; j++)
				adj[j] = 0;
			for (int s = 0; s < held_count; s++) begin
				for (int j = 0; j < 4; j++)
					x[j] = held_x[s][j];
				o = sigmoid_of(dot_with(x, n));
				err = longint'(held_target[s]) - o;
				slope = (o * (65536 - o)) >>> 16;
				delta = (err * slope) >>> 16;
				for (int j = 0; j < n; j++)
					adj[j] += x[j] * delta;
			end
			for (int j = 0; j < n; j++)
				weight[j] = clamp32(weight[j] + (adj[j] >>> 12));
		end
	endfunction

	function automatic outcome_t apply_request();
		outcome_t r;
		longint   x[4];
		x[0] = in_ch.feature_a;
		x[1] = in_ch.feature_b;
		x[2] = in_ch.feature_c;
		x[3] = in_ch.feature_d;
		r.kind = KIND_ERROR;
		r.prediction = '0;
		case (in_ch.mode)
			MODE_STORE: begin
				if (held_count < MAX_SAMPLES) begin
					for (int j = 0; j < 4; j++)
						held_x[held_count][j] = 16'(x[j]);
					held_target[held_count] = in_ch.target;
					held_count++;
					r.kind = KIND_STORED;
				end
			end
			MODE_TRAIN: begin
				run_training();
				r.kind = KIND_TRAINED;
			end
			MODE_INFER: begin
				r.prediction = 16'(sigmoid_of(dot_with(x, active_lanes())));
				r.kind = KIND_PREDICTION;
			end
			MODE_SET_WEIGHT: begin
				if (in_ch.weight_slot < MAX_FEATURES)
					weight[in_ch.weight_slot] = in_ch.weight_value;
				r.kind = KIND_WEIGHT_SET;
			end
			MODE_CLEAR: begin
				held_count = 0;
				r.kind = KIND_STORED;
			end
			default: ;
		endcase
		r.wa = 32'(weight[0]);
		r.wb = 32'(weight[1]);
		r.wc = 32'(weight[2]);
		r.wd = 32'(weight[3]);
		return r;
	endfunction

	task automatic report(string field, longint got, longint want);
		$display("MISMATCH %s: got %0d expected %0d", field, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
		held_count = 0;
		iterations = 10000;
		lanes_cfg = 3;
		for (int j = 0; j < 4; j++) begin
			weight[j] = 0;
			adj[j] = 0;
		end
	end

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				if (cfg_ch.index == CFG_ITERATION_COUNT)
					iterations = cfg_ch.data;
				else if (cfg_ch.index == CFG_FEATURES_IN_USE)
					lanes_cfg = cfg_ch.data[2:0];
			end
			if (out_ch.valid && out_ch.ready) begin
				if (outcomes_due.size() == 0) begin
					$display("MISMATCH result with nothing pending, kind %0d", out_ch.kind);
					errors++;
				end else begin
					want = outcomes_due.pop_front();
					if (out_ch.kind !== want.kind)
						report("kind", out_ch.kind, want.kind);
					if (out_ch.prediction !== want.prediction)
						report("prediction", out_ch.prediction, want.prediction);
					if (out_ch.weight_out_a !== want.wa)
						report("weight_out_a", out_ch.weight_out_a, want.wa);
					if (out_ch.weight_out_b !== want.wb)
						report("weight_out_b", out_ch.weight_out_b, want.wb);
					if (out_ch.weight_out_c !== want.wc)
						report("weight_out_c", out_ch.weight_out_c, want.wc);
					if (out_ch.weight_out_d !== want.wd)
						report("weight_out_d", out_ch.weight_out_d, want.wd);
				end
			end
			if (in_ch.valid && in_ch.ready)
				outcomes_due.push_back(apply_request());
			pending = outcomes_due.size();
		end
	end

endmodule

FILE: bench/tb_single_neuron_sigmoid_trainer_top.sv
// ----------------------------------------------------------------------------
// tb_single_neuron_sigmoid_trainer_top
// Stimulus and verdict for the neuron trainer. Drives directed and random
// requests and register writes; a checker beside the block predicts and checks.
// ----------------------------------------------------------------------------
module tb_single_neuron_sigmoid_trainer_top;
	import snst_pkg::*;

	// modes above the clear code are unused and must answer with an error
	localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
	localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
	localparam int         STORE_DEPTH    = 16;
	localparam int         RANDOM_PHASES  = 28;
	localparam int         PHASE_ITEMS    = 40;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	bit   stall_on;
	bit   gaps_on;

	snst_in_if  in_ch();
	snst_out_if out_ch();
	snst_cfg_if cfg_ch();

	single_neuron_sigmoid_trainer_top #(.MAX_SAMPLES(STORE_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	snst_checker #(.MAX_SAMPLES(STORE_DEPTH)) u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.cfg_ch  (cfg_ch),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop: the slowest correct run (long directed trainings plus the
	// random phases under full stalling) stays well below this.
	initial begin
		#16000000;
		$display("DONE: errors detected");
		$finish;
	end

	// Result side: hold ready low in random bursts while stalling is on.
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_on && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	// Feature in Q4.12: a value within +-2 so training moves, any value of the full
	// range, or an extreme to reach the saturating ends of the sigmoid.
	function automatic logic [15:0] pick_feature();
		case ($urandom_range(0, 5))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2, 3:    return 16'($urandom_range(0, 16'h3FFF)) - 16'h2000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_weight();
		case ($urandom_range(0, 5))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2, 3:    return 32'($urandom_range(0, 32'h0003_FFFF)) - 32'h0002_0000;
			default: return $urandom;
		endcase
	endfunction

	// Drive one request. Drop valid for a gap first if asked; otherwise keep
	// it high from the previous request so there is one assignment per edge.
	task automatic send(logic [2:0] mode, logic [15:0] fa, logic [15:0] fb,
		logic [15:0] fc, logic [15:0] fd, logic [15:0] tgt,
		logic [1:0] slot, logic [31:0] wval);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.mode         <= mode;
		in_ch.feature_a    <= fa;
		in_ch.feature_b    <= fb;
		in_ch.feature_c    <= fc;
		in_ch.feature_d    <= fd;
		in_ch.target       <= tgt;
		in_ch.weight_slot  <= slot;
		in_ch.weight_value <= wval;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// request with random content around a chosen mode
	task automatic send_mode(logic [2:0] mode);
		send(mode, pick_feature(), pick_feature(), pick_feature(), pick_feature(),
			16'($urandom), 2'($urandom), pick_weight());
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	// Drain: drop valid, wait for every result, then let the block settle.
	task automatic drain();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic configure(logic [15:0] iters, logic [15:0] lanes);
		write_reg(CFG_ITERATION_COUNT, iters);
		write_reg(CFG_FEATURES_IN_USE, lanes);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		in_ch.valid        <= 1'b0;
		in_ch.mode         <= MODE_STORE;
		in_ch.feature_a    <= '0;
		in_ch.feature_b    <= '0;
		in_ch.feature_c    <= '0;
		in_ch.feature_d    <= '0;
		in_ch.target       <= '0;
		in_ch.weight_slot  <= '0;
		in_ch.weight_value <= '0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.index       <= CFG_ITERATION_COUNT;
		cfg_ch.data        <= '0;
		arst_n             <= 1'b0;
		stall_on = 1'b1;
		gaps_on  = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: 10000 passes, three lanes. Infer with zero weights,
		// load weight extremes, try unused modes, then train with an empty store and with one sample.
		send(MODE_INFER, 16'h7FFF, 16'h8000, 16'h1000, 16'h0000, '0, '0, '0);
		send(MODE_SET_WEIGHT, '0, '0, '0, '0, '0, 2'd0, 32'h7FFF_FFFF);
		send(MODE_SET_WEIGHT, '0, '0, '0, '0, '0, 2'd1, 32'h8000_0000);
		send(MODE_SET_WEIGHT, '0, '0, '0, '0, '0, 2'd2, 32'h0000_0001);
		send(MODE_SET_WEIGHT, '0, '0, '0, '0, '0, 2'd3, 32'hFFFF_FFFF);
		send(MODE_INFER, 16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF, '0, '0, '0);
		send(MODE_INFER, 16'h8000, 16'h0000, 16'h0000, 16'h0000, '0, '0, '0);
		send(MODE_UNUSED_LO, '1, '1, '1, '1, '1, '1, '1);
		send(MODE_UNUSED_HI, '0, '0, '0, '0, '0, '0, '0);
		send(MODE_TRAIN, '0, '0, '0, '0, '0, '0, '0);
		send(MODE_SET_WEIGHT, '0, '0, '0, '0, '0, 2'd0, 32'h0000_0000);
		send(MODE_SET_WEIGHT, '0, '0, '0, '0, '0, 2'd1, 32'h0000_0000);
		send(MODE_STORE, 16'h1000, 16'hF000, 16'h0800, 16'h7FFF, 16'hFFFF, '0, '0);
		send(MODE_TRAIN, '0, '0, '0, '0, '0, '0, '0);
		drain();

		// Zero passes and a lane count above the maximum; fill the store
		// until it refuses a sample.
		configure(16'd0, 16'd7);
		send(MODE_CLEAR, '0, '0, '0, '0, '0, '0, '0);
		for (int i = 0; i <= STORE_DEPTH; i++)
			send_mode(MODE_STORE);
		send(MODE_TRAIN, '0, '0, '0, '0, '0, '0, '0);
		send_mode(MODE_INFER);
		drain();

		// Most passes and lane count zero on an empty store.
		configure(16'hFFFF, 16'd0);
		send(MODE_CLEAR, '0, '0, '0, '0, '0, '0, '0);
		send(MODE_TRAIN, '0, '0, '0, '0, '0, '0, '0);
		send_mode(MODE_INFER);
		drain();

		// Random phases: each takes new settings, then a random mix of mostly valid
		// requests (store, infer, set weight, train, clear) with unused modes mixed in.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == RANDOM_PHASES - 1) begin
				stall_on = 1'b0;
				gaps_on  = 1'b0;
			end else begin
				stall_on = ($urandom_range(0, 3) != 0);
				gaps_on  = ($urandom_range(0, 3) != 0);
			end
			configure(($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 4)),
				16'($urandom_range(0, 7)));
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				case ($urandom_range(0, 99)) inside
					[0:39]:  send_mode(MODE_STORE);
					[40:64]: send_mode(MODE_INFER);
					[65:74]: send_mode(MODE_SET_WEIGHT);
					[75:82]: send_mode(MODE_TRAIN);
					[83:88]: send_mode(MODE_CLEAR);
					default: send_mode(3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)));
				endcase
			end
			drain();
		end

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
